// ----- sv/srtn_pkg.sv -----
// ============================================================================
// srtn_pkg
// Shared types and constants for the shortest-remaining-time-next scheduler.
// ============================================================================
package srtn_pkg;

    // Default configuration of the scheduler.
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int PID_W   = 8;
    localparam int ORDER_W = 16;
    localparam int FIELD_W = 16;

    // Input command codes.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Broadcast operations from the controller to the slot cells.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC   = 2'd2;

    // Status flags that travel along the cell row with the candidate word.
    typedef struct packed {
        logic best_valid;
        logic free_found;
    } srtn_flags_t;

endpackage

// ----- sv/srtn_cell.sv -----
// ============================================================================
// srtn_cell
// One process table slot. Compares its own entry against the candidate word
// from the previous cell and registers the better one toward the next cell.
// ============================================================================
module srtn_cell #(
    parameter int TIME_BITS = srtn_pkg::TIME_BITS_DEF,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Global state broadcast
    input  logic [TIME_BITS-1:0]         cur_time,
    input  logic [srtn_pkg::ORDER_W-1:0] ins_count,
    // Update broadcast
    input  logic [srtn_pkg::OP_W-1:0]    cmd_op,
    input  logic [IDX_W-1:0]             cmd_idx,
    input  logic [srtn_pkg::PID_W-1:0]   wr_pid,
    input  logic [TIME_BITS-1:0]         wr_arr,
    input  logic [TIME_BITS-1:0]         wr_burst,
    // Candidate from the previous cell
    input  srtn_pkg::srtn_flags_t        flags_in,
    input  logic [IDX_W-1:0]             free_idx_in,
    input  logic [IDX_W-1:0]             best_idx_in,
    input  logic [srtn_pkg::PID_W-1:0]   best_pid_in,
    input  logic [TIME_BITS-1:0]         best_arr_in,
    input  logic [TIME_BITS-1:0]         best_burst_in,
    input  logic [TIME_BITS-1:0]         best_rem_in,
    input  logic [srtn_pkg::ORDER_W-1:0] best_age_in,
    // Candidate toward the next cell
    output srtn_pkg::srtn_flags_t        flags_out,
    output logic [IDX_W-1:0]             free_idx_out,
    output logic [IDX_W-1:0]             best_idx_out,
    output logic [srtn_pkg::PID_W-1:0]   best_pid_out,
    output logic [TIME_BITS-1:0]         best_arr_out,
    output logic [TIME_BITS-1:0]         best_burst_out,
    output logic [TIME_BITS-1:0]         best_rem_out,
    output logic [srtn_pkg::ORDER_W-1:0] best_age_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // Slot contents
    logic                         used_reg, used_next;
    logic [srtn_pkg::PID_W-1:0]   pid_reg;
    logic [TIME_BITS-1:0]         arr_reg;
    logic [TIME_BITS-1:0]         burst_reg;
    logic [TIME_BITS-1:0]         rem_reg;
    logic [srtn_pkg::ORDER_W-1:0] order_reg;

    // Candidate registers
    srtn_pkg::srtn_flags_t        flags_reg, flags_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    logic [srtn_pkg::PID_W-1:0]   best_pid_reg, best_pid_next;
    logic [TIME_BITS-1:0]         best_arr_reg, best_arr_next;
    logic [TIME_BITS-1:0]         best_burst_reg, best_burst_next;
    logic [TIME_BITS-1:0]         best_rem_reg, best_rem_next;
    logic [srtn_pkg::ORDER_W-1:0] best_age_reg, best_age_next;

    logic                         hit;
    logic                         eligible;
    logic                         wins;
    logic [srtn_pkg::ORDER_W-1:0] own_age;

    assign hit      = (cmd_idx == MY_IDX);
    assign own_age  = order_reg - ins_count;
    assign eligible = used_reg && (rem_reg != '0) && (arr_reg <= cur_time);

    // Ordering: least remaining time, then earliest arrival, then oldest insertion.
    always_comb
    begin
        wins = 1'b0;
        if (eligible)
        begin
            if (!flags_in.best_valid)
                wins = 1'b1;
            else if (rem_reg != best_rem_in)
                wins = (rem_reg < best_rem_in);
            else if (arr_reg != best_arr_in)
                wins = (arr_reg < best_arr_in);
            else
                wins = (own_age < best_age_in);
        end
    end

    // Merge own entry into the passing candidate word.
    always_comb
    begin
        flags_next.best_valid = flags_in.best_valid | wins;
        flags_next.free_found = flags_in.free_found | ~used_reg;
        free_idx_next         = flags_in.free_found ? free_idx_in : MY_IDX;
        best_idx_next         = wins ? MY_IDX    : best_idx_in;
        best_pid_next         = wins ? pid_reg   : best_pid_in;
        best_arr_next         = wins ? arr_reg   : best_arr_in;
        best_burst_next       = wins ? burst_reg : best_burst_in;
        best_rem_next         = wins ? rem_reg   : best_rem_in;
        best_age_next         = wins ? own_age   : best_age_in;
    end

    // Occupancy update from the broadcast operation.
    always_comb
    begin
        used_next = used_reg;
        if (hit)
        begin
            case (cmd_op)
                srtn_pkg::OP_WRITE: used_next = 1'b1;
                srtn_pkg::OP_DEC:   used_next = (rem_reg != TIME_BITS'(1));
                default:            used_next = used_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            flags_reg <= flags_next;
        end
    end

    // Slot payload, written only on a matching broadcast.
    always_ff @(posedge clk)
    begin
        if (hit && cmd_op == srtn_pkg::OP_WRITE)
        begin
            pid_reg   <= wr_pid;
            arr_reg   <= wr_arr;
            burst_reg <= wr_burst;
            rem_reg   <= wr_burst;
            order_reg <= ins_count;
        end
        else if (hit && cmd_op == srtn_pkg::OP_DEC)
        begin
            rem_reg <= rem_reg - TIME_BITS'(1);
        end
    end

    // Candidate payload toward the next cell.
    always_ff @(posedge clk)
    begin
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_pid_reg   <= best_pid_next;
        best_arr_reg   <= best_arr_next;
        best_burst_reg <= best_burst_next;
        best_rem_reg   <= best_rem_next;
        best_age_reg   <= best_age_next;
    end

    assign flags_out      = flags_reg;
    assign free_idx_out   = free_idx_reg;
    assign best_idx_out   = best_idx_reg;
    assign best_pid_out   = best_pid_reg;
    assign best_arr_out   = best_arr_reg;
    assign best_burst_out = best_burst_reg;
    assign best_rem_out   = best_rem_reg;
    assign best_age_out   = best_age_reg;

endmodule

// ----- sv/srtn_tick_scheduler.sv -----
// ============================================================================
// srtn_tick_scheduler
// Preemptive shortest-remaining-time-next scheduler built on a row of slots.
// ============================================================================
// The process table is a row of TABLE_SLOTS cells. Each cell holds one entry
// and every cycle passes a candidate word (best eligible entry so far and the
// lowest free slot) to its right neighbor through its candidate registers. An
// item is accepted in the idle state, the scan state lets the row settle, and
// the apply state applies the add or tick and loads the result; a new word is
// accepted only after the previous one has been applied. The result sits in an
// output register and the next word can be accepted while it waits; the update
// of a following word waits only if the previous result has not been taken.
// ============================================================================
module srtn_tick_scheduler #(
    parameter int TABLE_SLOTS = srtn_pkg::TABLE_SLOTS_DEF,
    parameter int TIME_BITS   = srtn_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [srtn_pkg::PID_W-1:0]   process_id,
    input  logic [srtn_pkg::FIELD_W-1:0] arrival_time,
    input  logic [srtn_pkg::FIELD_W-1:0] burst_time,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         add_rejected,
    output logic                         ran_valid,
    output logic [srtn_pkg::PID_W-1:0]   ran_process,
    output logic                         finished,
    output logic [srtn_pkg::FIELD_W-1:0] turnaround,
    output logic [srtn_pkg::FIELD_W-1:0] waiting,
    output logic [srtn_pkg::FIELD_W-1:0] clock_now
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(TABLE_SLOTS - 1);

    // Control state
    logic [1:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]         time_reg, time_next;
    logic [srtn_pkg::ORDER_W-1:0] ins_cnt_reg, ins_cnt_next;
    logic                         out_valid_reg, out_valid_next;

    // Captured input word
    logic                         cmd_reg;
    logic [srtn_pkg::PID_W-1:0]   pid_reg;
    logic [TIME_BITS-1:0]         arr_reg;
    logic [TIME_BITS-1:0]         burst_reg;

    // Result registers
    logic                         rejected_reg;
    logic                         ran_reg;
    logic [srtn_pkg::PID_W-1:0]   ran_pid_reg;
    logic                         fin_reg;
    logic [srtn_pkg::FIELD_W-1:0] tat_reg;
    logic [srtn_pkg::FIELD_W-1:0] wt_reg;
    logic [srtn_pkg::FIELD_W-1:0] clk_now_reg;

    // Cell row taps: entry i feeds cell i, entry i+1 is its output.
    srtn_pkg::srtn_flags_t        ch_flags    [TABLE_SLOTS+1];
    logic [IDX_W-1:0]             ch_free_idx [TABLE_SLOTS+1];
    logic [IDX_W-1:0]             ch_idx      [TABLE_SLOTS+1];
    logic [srtn_pkg::PID_W-1:0]   ch_pid      [TABLE_SLOTS+1];
    logic [TIME_BITS-1:0]         ch_arr      [TABLE_SLOTS+1];
    logic [TIME_BITS-1:0]         ch_burst    [TABLE_SLOTS+1];
    logic [TIME_BITS-1:0]         ch_rem      [TABLE_SLOTS+1];
    logic [srtn_pkg::ORDER_W-1:0] ch_age      [TABLE_SLOTS+1];

    // Broadcast operation
    logic [srtn_pkg::OP_W-1:0]    cmd_op;
    logic [IDX_W-1:0]             cmd_idx;

    logic                         in_fire;
    logic                         apply_go;
    logic                         do_write;
    logic                         do_dec;
    logic [TIME_BITS-1:0]         tick_time;
    logic [TIME_BITS-1:0]         tat_calc;
    logic [TIME_BITS-1:0]         wt_calc;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);

    // The head of the row starts with an empty candidate.
    assign ch_flags[0]    = '0;
    assign ch_free_idx[0] = '0;
    assign ch_idx[0]      = '0;
    assign ch_pid[0]      = '0;
    assign ch_arr[0]      = '0;
    assign ch_burst[0]    = '0;
    assign ch_rem[0]      = '0;
    assign ch_age[0]      = '0;

    // Row of slot cells.
    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_cell
        srtn_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cur_time       (time_reg),
            .ins_count      (ins_cnt_reg),
            .cmd_op         (cmd_op),
            .cmd_idx        (cmd_idx),
            .wr_pid         (pid_reg),
            .wr_arr         (arr_reg),
            .wr_burst       (burst_reg),
            .flags_in       (ch_flags[i]),
            .free_idx_in    (ch_free_idx[i]),
            .best_idx_in    (ch_idx[i]),
            .best_pid_in    (ch_pid[i]),
            .best_arr_in    (ch_arr[i]),
            .best_burst_in  (ch_burst[i]),
            .best_rem_in    (ch_rem[i]),
            .best_age_in    (ch_age[i]),
            .flags_out      (ch_flags[i+1]),
            .free_idx_out   (ch_free_idx[i+1]),
            .best_idx_out   (ch_idx[i+1]),
            .best_pid_out   (ch_pid[i+1]),
            .best_arr_out   (ch_arr[i+1]),
            .best_burst_out (ch_burst[i+1]),
            .best_rem_out   (ch_rem[i+1]),
            .best_age_out   (ch_age[i+1])
        );
    end

    // Decide the update from the settled candidate at the end of the row.
    assign do_write = apply_go && (cmd_reg == srtn_pkg::CMD_ADD) && (burst_reg != '0)
                      && ch_flags[TABLE_SLOTS].free_found;
    assign do_dec   = apply_go && (cmd_reg == srtn_pkg::CMD_TICK)
                      && ch_flags[TABLE_SLOTS].best_valid;

    always_comb
    begin
        cmd_op  = srtn_pkg::OP_NONE;
        cmd_idx = ch_free_idx[TABLE_SLOTS];
        if (do_write)
        begin
            cmd_op  = srtn_pkg::OP_WRITE;
            cmd_idx = ch_free_idx[TABLE_SLOTS];
        end
        else if (do_dec)
        begin
            cmd_op  = srtn_pkg::OP_DEC;
            cmd_idx = ch_idx[TABLE_SLOTS];
        end
    end

    // Completion times use the clock after this tick.
    assign tick_time = time_reg + TIME_BITS'(1);
    assign tat_calc  = tick_time - ch_arr[TABLE_SLOTS];
    assign wt_calc   = tat_calc - ch_burst[TABLE_SLOTS];

    // Sequencer and global counters.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        time_next      = time_reg;
        ins_cnt_next   = ins_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == SCAN_LAST)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (cmd_reg == srtn_pkg::CMD_TICK)
                        time_next = tick_time;
                    if (do_write)
                        ins_cnt_next = ins_cnt_reg + srtn_pkg::ORDER_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            time_reg      <= '0;
            ins_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            time_reg      <= time_next;
            ins_cnt_reg   <= ins_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word; times are taken modulo the clock width.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= command;
            pid_reg   <= process_id;
            arr_reg   <= TIME_BITS'(arrival_time);
            burst_reg <= TIME_BITS'(burst_time);
        end
    end

    // Load the result word.
    always_ff @(posedge clk)
    begin
        if (apply_go)
        begin
            rejected_reg <= (cmd_reg == srtn_pkg::CMD_ADD) && (burst_reg != '0)
                            && !ch_flags[TABLE_SLOTS].free_found;
            ran_reg      <= do_dec;
            ran_pid_reg  <= do_dec ? ch_pid[TABLE_SLOTS] : '0;
            fin_reg      <= do_dec && (ch_rem[TABLE_SLOTS] == TIME_BITS'(1));
            if (do_dec && (ch_rem[TABLE_SLOTS] == TIME_BITS'(1)))
            begin
                tat_reg <= srtn_pkg::FIELD_W'(tat_calc);
                wt_reg  <= srtn_pkg::FIELD_W'(wt_calc);
            end
            else
            begin
                tat_reg <= '0;
                wt_reg  <= '0;
            end
            if (cmd_reg == srtn_pkg::CMD_TICK)
                clk_now_reg <= srtn_pkg::FIELD_W'(tick_time);
            else
                clk_now_reg <= srtn_pkg::FIELD_W'(time_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign add_rejected = rejected_reg;
    assign ran_valid    = ran_reg;
    assign ran_process  = ran_pid_reg;
    assign finished     = fin_reg;
    assign turnaround   = tat_reg;
    assign waiting      = wt_reg;
    assign clock_now    = clk_now_reg;

`ifndef ASSERT_OFF
    // One word at a time: an accepted word closes the input until it is done.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // The clock only moves when a word is applied.
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !apply_go |=> $stable(time_reg))
        else $error("clock changed outside the apply step");

    // The insertion counter only moves when a word is applied.
    a_ins_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !apply_go |=> $stable(ins_cnt_reg))
        else $error("insertion counter changed outside the apply step");

    // A completion is always a served tick.
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!finished || ran_valid))
        else $error("finished without a served process");

    // A rejected add and a served tick never share a result.
    a_rej_ran: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(add_rejected && ran_valid))
        else $error("rejected add reported with a served tick");
`endif

endmodule

// ----- sim/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking regression for the shortest-remaining-time-next scheduler.
// ============================================================================
// A queue of words is filled up front. It starts with a directed opening: an
// idle tick, a zero-burst add, an entry that never becomes eligible, ties on
// remaining time, arrival and insertion order, duplicate ids and a full
// table. A random mix of add and tick words with mostly reachable arrivals
// follows, and the add rate alternates so that the table fills and drains. A
// clocked driver offers the words with random gaps. A clocked monitor takes
// results with random stalls, and once holds off for a long stretch. Each
// accepted word runs through a scheduler model kept in the bench. Every
// result is compared with the oldest prediction that is still pending.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = srtn_pkg::TABLE_SLOTS_DEF;
    localparam int PID_W        = srtn_pkg::PID_W;
    localparam int FIELD_W      = srtn_pkg::FIELD_W;
    localparam int ORDER_W      = srtn_pkg::ORDER_W;
    localparam int RANDOM_WORDS = 800;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);

    typedef struct packed {
        logic               cmd;
        logic [PID_W-1:0]   pid;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
    } sched_word_t;

    typedef struct packed {
        logic               rejected;
        logic               ran;
        logic [PID_W-1:0]   pid;
        logic               fin;
        logic [FIELD_W-1:0] tat;
        logic [FIELD_W-1:0] wt;
        logic [FIELD_W-1:0] clk_now;
    } sched_result_t;

    // Clock, reset and the ports of the block.
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               command      = srtn_pkg::CMD_ADD;
    logic [PID_W-1:0]   process_id   = '0;
    logic [FIELD_W-1:0] arrival_time = '0;
    logic [FIELD_W-1:0] burst_time   = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic               add_rejected;
    logic               ran_valid;
    logic [PID_W-1:0]   ran_process;
    logic               finished;
    logic [FIELD_W-1:0] turnaround;
    logic [FIELD_W-1:0] waiting;
    logic [FIELD_W-1:0] clock_now;

    // Stimulus and expectations.
    sched_word_t   word_queue[$];
    sched_result_t result_due[$];
    logic [FIELD_W-1:0] plan_time = '0;
    logic          hold_off   = 1'b0;
    int unsigned   gap_left   = 0;
    int unsigned   stall_left = 0;
    int unsigned   words_taken  = 0;
    int unsigned   results_seen = 0;
    int unsigned   fail_count   = 0;

    // Process table of the scheduler model.
    logic               tbl_busy[SLOTS];
    logic [PID_W-1:0]   tbl_pid[SLOTS];
    logic [FIELD_W-1:0] tbl_arrival[SLOTS];
    logic [FIELD_W-1:0] tbl_burst[SLOTS];
    logic [FIELD_W-1:0] tbl_left[SLOTS];
    logic [ORDER_W-1:0] tbl_seq[SLOTS];
    logic [ORDER_W-1:0] seq_count = '0;
    logic [FIELD_W-1:0] sim_time  = '0;
    int unsigned n_stored   = 0;
    int unsigned n_rejected = 0;
    int unsigned n_served   = 0;
    int unsigned n_finished = 0;
    int unsigned n_idle     = 0;

    srtn_tick_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .process_id   (process_id),
        .arrival_time (arrival_time),
        .burst_time   (burst_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .add_rejected (add_rejected),
        .ran_valid    (ran_valid),
        .ran_process  (ran_process),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .clock_now    (clock_now)
    );

    always #1 clk = ~clk;

    // Applies one word to the model table and returns the result it causes.
    function automatic sched_result_t schedule_word(input sched_word_t w);
        sched_result_t      r;
        int                 best;
        logic               take;
        logic [ORDER_W-1:0] age_i;
        logic [ORDER_W-1:0] age_b;
        logic [FIELD_W-1:0] span;
        r = '0;
        best = -1;
        if (w.cmd == srtn_pkg::CMD_ADD)
        begin
            // A zero burst stores nothing and is not flagged.
            if (w.burst != '0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (best < 0 && !tbl_busy[i])
                        best = i;
                if (best < 0)
                begin
                    r.rejected = 1'b1;
                    n_rejected++;
                end
                else
                begin
                    tbl_busy[best]    = 1'b1;
                    tbl_pid[best]     = w.pid;
                    tbl_arrival[best] = w.arrival;
                    tbl_burst[best]   = w.burst;
                    tbl_left[best]    = w.burst;
                    tbl_seq[best]     = seq_count;
                    seq_count         = seq_count + 1'b1;
                    n_stored++;
                end
            end
        end
        else
        begin
            // Least remaining time, then earlier arrival, then older insertion.
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tbl_busy[i] && tbl_left[i] != '0 && tbl_arrival[i] <= sim_time)
                begin
                    if (best < 0)
                        take = 1'b1;
                    else if (tbl_left[i] != tbl_left[best])
                        take = tbl_left[i] < tbl_left[best];
                    else if (tbl_arrival[i] != tbl_arrival[best])
                        take = tbl_arrival[i] < tbl_arrival[best];
                    else
                    begin
                        age_i = tbl_seq[i] - seq_count;
                        age_b = tbl_seq[best] - seq_count;
                        take  = age_i < age_b;
                    end
                    if (take)
                        best = i;
                end
            end
            sim_time = sim_time + 1'b1;
            if (best < 0)
                n_idle++;
            else
            begin
                r.ran = 1'b1;
                r.pid = tbl_pid[best];
                tbl_left[best] = tbl_left[best] - 1'b1;
                n_served++;
                if (tbl_left[best] == '0)
                begin
                    span   = sim_time - tbl_arrival[best];
                    r.fin  = 1'b1;
                    r.tat  = span;
                    r.wt   = span - tbl_burst[best];
                    tbl_busy[best] = 1'b0;
                    n_finished++;
                end
            end
        end
        r.clk_now = sim_time;
        return r;
    endfunction

    // Queues one word and tracks the time that the block will have reached.
    task automatic queue_word(input logic cmd, input logic [PID_W-1:0] pid,
                              input logic [FIELD_W-1:0] arrival,
                              input logic [FIELD_W-1:0] burst);
        word_queue.push_back('{cmd: cmd, pid: pid, arrival: arrival, burst: burst});
        if (cmd == srtn_pkg::CMD_TICK)
            plan_time = plan_time + 1'b1;
    endtask

    // Every third stretch of 64 words runs without pauses.
    function automatic int unsigned pause_len(input int unsigned n);
        if ((n / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Driver: offers queued words and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        sched_word_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                result_due.push_back(schedule_word({command, process_id,
                                                    arrival_time, burst_time}));
                words_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() != 0)
                begin
                    nxt = word_queue.pop_front();
                    command      <= nxt.cmd;
                    process_id   <= nxt.pid;
                    arrival_time <= nxt.arrival;
                    burst_time   <= nxt.burst;
                    in_valid     <= 1'b1;
                    gap_left     <= pause_len(words_taken);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: takes results with random stalls and checks each one.
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        int unsigned   stall_nxt;
        if (rst_n)
        begin
            stall_nxt = stall_left;
            if (out_valid && out_ready)
            begin
                got = {add_rejected, ran_valid, ran_process, finished,
                       turnaround, waiting, clock_now};
                if (result_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("result %0d arrived with no word pending", results_seen);
                end
                else
                begin
                    want = result_due.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_SHOWN)
                        begin
                            $display("mismatch on result %0d", results_seen);
                            $display("  expected rej=%0b ran=%0b pid=%02h fin=%0b",
                                     want.rejected, want.ran, want.pid, want.fin);
                            $display("  expected tat=%0d wt=%0d now=%0d",
                                     want.tat, want.wt, want.clk_now);
                            $display("  got      rej=%0b ran=%0b pid=%02h fin=%0b",
                                     got.rejected, got.ran, got.pid, got.fin);
                            $display("  got      tat=%0d wt=%0d now=%0d",
                                     got.tat, got.wt, got.clk_now);
                        end
                    end
                end
                results_seen++;
                stall_nxt = pause_len(results_seen);
            end
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_nxt != 0)
            begin
                out_ready <= 1'b0;
                stall_nxt = stall_nxt - 1;
            end
            else
                out_ready <= 1'b1;
            stall_left <= stall_nxt;
        end
    end

    // Long receiver hold-off so that the block fills up and stalls its input.
    initial
    begin
        wait (words_taken >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #500_000;
        $display("srtn_tick_scheduler regression: fail");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic               heavy;
        logic [PID_W-1:0]   pid;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        int unsigned        back;
        int unsigned        pick;

        for (int i = 0; i < SLOTS; i++)
            tbl_busy[i] = 1'b0;

        // Directed opening: idle tick on an empty table, zero burst, an entry
        // that never becomes eligible, and an entry that finishes at once.
        queue_word(srtn_pkg::CMD_TICK, 8'h00, 16'h0000, 16'h0000);
        queue_word(srtn_pkg::CMD_ADD,  8'h05, 16'h0000, 16'h0000);
        queue_word(srtn_pkg::CMD_ADD,  8'hFF, 16'hFFFF, 16'hFFFF);
        queue_word(srtn_pkg::CMD_ADD,  8'h00, 16'h0000, 16'h0001);
        queue_word(srtn_pkg::CMD_TICK, 8'h00, 16'h0000, 16'h0000);
        // Ties on remaining time, arrival and insertion, duplicate ids, and a
        // later short arrival that preempts.
        queue_word(srtn_pkg::CMD_ADD,  8'h11, 16'h0002, 16'h0003);
        queue_word(srtn_pkg::CMD_ADD,  8'h22, 16'h0002, 16'h0003);
        queue_word(srtn_pkg::CMD_ADD,  8'h11, 16'h0001, 16'h0003);
        queue_word(srtn_pkg::CMD_ADD,  8'h33, 16'h0004, 16'h0001);
        repeat (3)
            queue_word(srtn_pkg::CMD_TICK, 8'hAA, 16'h5555, 16'h5555);
        // Fill the table and then overflow it.
        for (int i = 0; i < 13; i++)
            queue_word(srtn_pkg::CMD_ADD, 8'h40 + i[7:0], plan_time + 16'd1,
                       16'd1 + i[15:0] % 2);

        // Random part: add rate alternates between heavy and light blocks.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            heavy = ((n / 100) % 2) == 0;
            if ($urandom_range(0, 199) == 0)
                queue_word(1'($urandom_range(0, 1)), PID_W'($urandom),
                           FIELD_W'($urandom), FIELD_W'($urandom));
            else if ($urandom_range(0, 99) < (heavy ? 50 : 20))
            begin
                pid  = PID_W'($urandom);
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    arrival = plan_time + FIELD_W'($urandom_range(0, 12));
                else if (pick == 8)
                begin
                    back = 40;
                    if (plan_time < 16'd40)
                        back = 32'(plan_time);
                    arrival = plan_time - FIELD_W'($urandom_range(0, back));
                end
                else
                    arrival = '0;
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    burst = '0;
                else if (pick < 4)
                    burst = FIELD_W'($urandom_range(5, 30));
                else
                    burst = FIELD_W'($urandom_range(1, 4));
                queue_word(srtn_pkg::CMD_ADD, pid, arrival, burst);
            end
            else
                queue_word(srtn_pkg::CMD_TICK, PID_W'($urandom),
                           FIELD_W'($urandom), FIELD_W'($urandom));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (word_queue.size() != 0 || in_valid || result_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Any prediction still pending means a result never came out.
        if (result_due.size() != 0)
        begin
            fail_count++;
            $display("%0d results never arrived", result_due.size());
        end

        $display("Covered %0d words: %0d adds stored, %0d rejected on a full table.",
                 words_taken, n_stored, n_rejected);
        $display("Ticks served %0d times with %0d completions, %0d ticks idle, %0d errors.",
                 n_served, n_finished, n_idle, fail_count);
        if (fail_count == 0)
            $display("srtn_tick_scheduler regression: pass");
        else
            $display("srtn_tick_scheduler regression: fail");
        $finish;
    end

endmodule
